// ===== rtl/fcca_pkg.sv =====
`default_nettype none

package fcca_pkg;

	// Default table depth and reset value of the scan base register.
	localparam int unsigned DEF_TABLE_ENTRIES = 4096;
	localparam logic [11:0] FDC_RESET         = 12'd2;

	// Value written to the last cluster of a chain.
	localparam logic [31:0] EOC_MIN = 32'h0FFF_FFF8;

	typedef enum logic [1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_ALLOC  = 2'd2,
		FUNC_EXTEND = 2'd3
	} func_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_ALLOC,
		ST_COUNT,
		ST_CLEAR,
		ST_LINK,
		ST_FINISH,
		ST_DONE
	} state_e_t;

	typedef struct packed {
		logic        status;
		logic [11:0] cluster;
		logic [31:0] read_data;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/fcca_table.sv =====
`default_nettype none

module fcca_table #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	// Simple dual-port table, one write and one registered read per cycle.
	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fcca_ctrl.sv =====
`default_nettype none

module fcca_ctrl #(
	parameter int unsigned TABLE_ENTRIES = 4096,
	parameter int unsigned AW            = 12,
	parameter int unsigned CW            = 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 take,
	input  wire logic [1:0]           func,
	input  wire logic [11:0]          index,
	input  wire logic [31:0]          value,
	input  wire logic [12:0]          count,
	input  wire logic [11:0]          first_data_cluster,
	output logic                      idle,
	output logic                      done,
	input  wire logic                 res_take,
	output fcca_pkg::result_t         res,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [31:0]               mem_wdata,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_raddr,
	input  wire logic [31:0]          mem_rdata
);

	import fcca_pkg::*;

	localparam logic [CW-1:0] N_C = CW'(TABLE_ENTRIES);

	state_e_t      state_q, state_d;
	logic [CW-1:0] addr_q, addr_d;
	logic [CW-1:0] tail_q, tail_d;
	logic [AW-1:0] cur_q, cur_d;
	logic [12:0]   found_q, found_d;
	logic [12:0]   want_q, want_d;
	result_t       res_q, res_d;
	logic          rd_v_s1;
	logic [CW-1:0] rd_a_s1;

	logic issue;
	logic rd_item;
	logic in_range;
	logic idx_ok;
	logic hit_free;
	logic not_tail;

	assign in_range = addr_q < N_C;
	assign idx_ok   = CW'(index) < N_C;
	assign hit_free = rd_v_s1 && (mem_rdata[30:0] == 31'd0);
	assign not_tail = rd_a_s1 != tail_q;
	assign res      = res_q;
	assign idle     = state_q == ST_IDLE;
	assign done     = state_q == ST_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_d;
		tail_q  <= tail_d;
		cur_q   <= cur_d;
		found_q <= found_d;
		want_q  <= want_d;
		res_q   <= res_d;
		rd_a_s1 <= addr_q;
	end

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		tail_d    = tail_q;
		cur_d     = cur_q;
		found_d   = found_q;
		want_d    = want_q;
		res_d     = res_q;
		issue     = 1'b0;
		rd_item   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					res_d = '0;
					unique case (func_e_t'(func))
						FUNC_WRITE: begin
							mem_we    = idx_ok;
							mem_waddr = AW'(index);
							mem_wdata = value;
							state_d   = ST_DONE;
						end
						FUNC_READ: begin
							rd_item = idx_ok;
							state_d = idx_ok ? ST_RD_WAIT : ST_DONE;
						end
						FUNC_ALLOC: begin
							addr_d  = CW'(first_data_cluster);
							state_d = ST_ALLOC;
						end
						FUNC_EXTEND: begin
							want_d  = count;
							tail_d  = CW'(index);
							cur_d   = AW'(index);
							addr_d  = CW'(first_data_cluster);
							found_d = '0;
							if (count == 13'd0) begin
								state_d = ST_DONE;
							end else if (!idx_ok) begin
								res_d.status = 1'b1;
								state_d      = ST_DONE;
							end else begin
								state_d = ST_COUNT;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				res_d.read_data = mem_rdata;
				state_d         = ST_DONE;
			end
			ST_ALLOC: begin
				issue = in_range;
				if (hit_free) begin
					issue         = 1'b0;
					mem_we        = 1'b1;
					mem_waddr     = rd_a_s1[AW-1:0];
					mem_wdata     = EOC_MIN;
					res_d.cluster = rd_a_s1[11:0];
					state_d       = ST_DONE;
				end else if (!in_range && !rd_v_s1) begin
					res_d.status = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_COUNT: begin
				issue = in_range;
				if (hit_free && not_tail && found_q != want_q) begin
					found_d = found_q + 13'd1;
				end
				if (!in_range && !rd_v_s1) begin
					addr_d = CW'(first_data_cluster);
					if (found_q == want_q) begin
						found_d = '0;
						state_d = ST_LINK;
					end else begin
						state_d = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				issue = in_range;
				if (hit_free && not_tail) begin
					mem_we    = 1'b1;
					mem_waddr = rd_a_s1[AW-1:0];
					mem_wdata = '0;
				end
				if (!in_range && !rd_v_s1) begin
					res_d.status = 1'b1;
					state_d      = ST_FINISH;
				end
			end
			ST_LINK: begin
				issue = in_range && (found_q != want_q);
				if (found_q == want_q) begin
					state_d = ST_FINISH;
				end else if (hit_free && not_tail) begin
					mem_we    = 1'b1;
					mem_waddr = cur_q;
					mem_wdata = 32'(rd_a_s1);
					cur_d     = rd_a_s1[AW-1:0];
					found_d   = found_q + 13'd1;
				end else if (!in_range && !rd_v_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = EOC_MIN;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (issue) begin
			addr_d = addr_q + CW'(1);
		end
		mem_re    = issue || rd_item;
		mem_raddr = rd_item ? AW'(index) : addr_q[AW-1:0];
	end

endmodule

`default_nettype wire

// ===== rtl/fat_cluster_chain_allocator_core.sv =====
`default_nettype none

// FAT cluster chain allocator.
// The input channel (in_valid / in_stall) carries one command item: func selects
// a table write, a table read, a one-cluster allocation for a new file, or a
// chain extend by count clusters from the tail given in index. Every item gives
// exactly one result item on the output channel (out_valid / out_stall) with
// status, cluster and read_data. The cfg channel (cfg_valid / cfg_ready) writes
// first_data_cluster, the lowest index that allocation scans; the user must
// write it only while the block is idle, which the block does not enforce, and
// cfg_ready is always high. The table sits in a simple dual-port RAM with one
// registered read port, and a scan streams one entry per cycle through that
// port. One item is in work at a time: a write goes from the idle state to the
// done state and then into the result register, and a read also passes through
// the read-wait state. An extend makes a counting pass over the scan range and
// then a linking or a release pass. The result register lets the next item be
// accepted while a result is held by out_stall; a second result waits inside
// the block until the first is taken. Reset clears the control state and sets
// first_data_cluster to 2; the table itself is not cleared and must be written
// before it is read.
module fat_cluster_chain_allocator_core #(
	parameter int unsigned TABLE_ENTRIES = fcca_pkg::DEF_TABLE_ENTRIES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [11:0] index,
	input  wire logic [31:0] value,
	input  wire logic [12:0] count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [11:0]      cluster,
	output logic [31:0]      read_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [11:0] cfg_data
);

	import fcca_pkg::*;

	// Address width of the table and width of the scan counter, which must
	// also hold the table size and any first_data_cluster value.
	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = ((AW > 12) ? AW : 12) + 1;

	logic [11:0]   fdc_q;
	logic          out_valid_q;
	result_t       out_q;
	logic          ctrl_idle;
	logic          ctrl_done;
	logic          res_load;
	result_t       ctrl_res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	// The sequencer takes a new item only in its idle state.
	assign in_stall  = !ctrl_idle;
	assign cfg_ready = 1'b1;

	// The result register loads when it is empty or being emptied this cycle.
	assign res_load = ctrl_done && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdc_q <= FDC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			fdc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= ctrl_res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign cluster   = out_q.cluster;
	assign read_data = out_q.read_data;

	fcca_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW           (AW),
		.CW           (CW)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.take              (in_valid && !in_stall),
		.func              (func),
		.index             (index),
		.value             (value),
		.count             (count),
		.first_data_cluster(fdc_q),
		.idle              (ctrl_idle),
		.done              (ctrl_done),
		.res_take          (res_load),
		.res               (ctrl_res),
		.mem_we            (mem_we),
		.mem_waddr         (mem_waddr),
		.mem_wdata         (mem_wdata),
		.mem_re            (mem_re),
		.mem_raddr         (mem_raddr),
		.mem_rdata         (mem_rdata)
	);

	fcca_table #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// An accepted item always keeps the sequencer busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// A finished result is never lost when the result register is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_done && !out_valid_q |=> out_valid_q)
		else $error("finished result not loaded");

	// A result with the no-space status never reports a cluster.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status |-> out_q.cluster == 12'd0)
		else $error("cluster reported with no-space status");

endmodule

`default_nettype wire

// ===== test/tb_fat_cluster_chain_allocator_core.sv =====
`default_nettype none

module tb_fat_cluster_chain_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fcca_pkg::*;

	// The table depth follows the default of the block, so the shadow table
	// and the scan loops below cover exactly the entries the block holds.
	localparam int unsigned TBL_ENTRIES   = DEF_TABLE_ENTRIES;
	localparam logic [31:0] FREE_MASK     = 32'h7FFF_FFFF;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned DRAIN_LIMIT   = 30000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned RANDOM_PHASE  = 16;
	// Lowest entry of the loaded top region; every scan range after the first directed items lies inside it.
	localparam int unsigned LOAD_BASE     = 4064;

	// One command item as it travels from the stimulus queue to the driver.
	typedef struct {
		func_e_t     func;
		logic [11:0] index;
		logic [31:0] value;
		logic [12:0] count;
	} fat_cmd_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [1:0]  func      = FUNC_WRITE;
	logic [11:0] index     = '0;
	logic [31:0] value     = '0;
	logic [12:0] count     = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [11:0] cluster;
	logic [31:0] read_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [11:0] cfg_data  = '0;

	// Commands waiting to be offered, and the results predicted for the
	// commands that the block has already taken, oldest first.
	fat_cmd_t command_q[$];
	result_t  predicted_results[$];

	// Shadow copy of the cluster table and of the scan base register.
	logic [31:0] fat_shadow[TBL_ENTRIES];
	logic [11:0] scan_base = FDC_RESET;

	int unsigned fail_count   = 0;
	int unsigned results_seen = 0;

	fat_cluster_chain_allocator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.index     (index),
		.value     (value),
		.count     (count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cluster   (cluster),
		.read_data (read_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// An entry counts as free when everything but the top bit is zero, so a
	// value of only bit 31 is free as well.
	function automatic bit entry_free(input int unsigned i);
		return (fat_shadow[i] & FREE_MASK) == '0;
	endfunction

	// Applies one command to the shadow table and returns the result that the
	// block must give for it.
	function automatic result_t apply_fat_command(input fat_cmd_t c);
		result_t     r;
		int unsigned i;
		int unsigned found;
		int unsigned cur;
		r = '0;
		case (c.func)
			FUNC_WRITE: fat_shadow[c.index] = c.value;
			FUNC_READ: r.read_data = fat_shadow[c.index];
			FUNC_ALLOC: begin
				// The first free entry at or above the scan base becomes a
				// one-cluster chain.
				r.status = 1'b1;
				for (i = scan_base; i < TBL_ENTRIES && r.status; i++)
					if (entry_free(i)) begin
						fat_shadow[i] = EOC_MIN;
						r.cluster = 12'(i);
						r.status = 1'b0;
					end
			end
			FUNC_EXTEND: if (c.count != '0) begin
				// Count the free entries first; the tail itself is never
				// taken even when it is free.
				found = 0;
				for (i = scan_base; i < TBL_ENTRIES && found < c.count; i++)
					if (i != c.index && entry_free(i))
						found++;
				if (found < c.count) begin
					// Not enough room: every free entry is released, and the
					// old tail ends its chain again.
					for (i = scan_base; i < TBL_ENTRIES; i++)
						if (i != c.index && entry_free(i))
							fat_shadow[i] = '0;
					fat_shadow[c.index] = EOC_MIN;
					r.status = 1'b1;
				end else begin
					cur = c.index;
					found = 0;
					for (i = scan_base; i < TBL_ENTRIES && found < c.count; i++)
						if (i != c.index && entry_free(i)) begin
							fat_shadow[cur] = i;
							cur = i;
							found++;
						end
					fat_shadow[cur] = EOC_MIN;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// Table contents: many free entries, some free ones with bit 31 set,
	// some chain ends and the rest arbitrary links.
	function automatic logic [31:0] entry_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return '0;
		if (r < 50)
			return 32'h8000_0000;
		if (r < 60)
			return EOC_MIN;
		return $urandom();
	endfunction

	function automatic fat_cmd_t random_command(input logic [11:0] base);
		fat_cmd_t    c;
		int unsigned r;
		int unsigned k;
		r = $urandom_range(0, 99);
		// Most indexes fall in the scan range so that writes, reads and
		// extends work on the entries the allocator touches; the rest may
		// also hit loaded entries below the scan base.
		if ($urandom_range(0, 4) == 0)
			c.index = 12'($urandom_range(LOAD_BASE, TBL_ENTRIES - 1));
		else
			c.index = 12'($urandom_range(base, TBL_ENTRIES - 1));
		c.value = entry_value();
		c.count = 13'($urandom_range(0, TBL_ENTRIES));
		if (r < 25)
			c.func = FUNC_WRITE;
		else if (r < 45)
			c.func = FUNC_READ;
		else if (r < 70)
			c.func = FUNC_ALLOC;
		else begin
			c.func = FUNC_EXTEND;
			k = $urandom_range(0, 19);
			if (k == 0)
				c.count = '0;
			else if (k < 14)
				c.count = 13'($urandom_range(1, 4));
			else if (k < 19)
				c.count = 13'($urandom_range(5, TBL_ENTRIES - base + 2));
			else
				c.count = 13'(TBL_ENTRIES);
		end
		return c;
	endfunction

	// Driver: offers the queued commands, keeps a stalled item steady, and
	// predicts each command at the edge where the block takes it.
	always @(posedge clk) begin : drive_commands
		fat_cmd_t    offered;
		int unsigned send_gap;
		int unsigned send_burst;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
			send_burst = 0;
		end else begin
			if (in_valid && !in_stall)
				predicted_results.push_back(apply_fat_command(offered));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (command_q.size() != 0) begin
					offered = command_q.pop_front();
					func <= offered.func;
					index <= offered.index;
					value <= offered.value;
					count <= offered.count;
					in_valid <= 1'b1;
					// Runs without gaps alternate with random idling.
					if (send_burst > 0) begin
						send_gap = 0;
						send_burst--;
					end else if ($urandom_range(0, 15) == 0) begin
						send_gap = 0;
						send_burst = $urandom_range(20, 60);
					end else begin
						send_gap = idle_len();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: random stalls and stall-free stretches, plus two long
	// hold-offs at fixed result counts. The first one falls in the table
	// load, where the sender keeps offering items, so the result register
	// and the block fill up and the input gets stalled.
	always @(posedge clk) begin : drive_stall
		int unsigned hold_left;
		int unsigned hold_idx;
		int unsigned stall_left;
		int unsigned flow_left;
		int unsigned hold_points[2];
		hold_points = '{12, 90};
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			hold_idx = 0;
			stall_left = 0;
			flow_left = 0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_idx < 2 && results_seen >= hold_points[hold_idx]) begin
			out_stall <= 1'b1;
			hold_left = LONG_HOLD - 1;
			hold_idx++;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (flow_left > 0) begin
			out_stall <= 1'b0;
			flow_left--;
		end else begin
			out_stall <= 1'b0;
			flow_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
				: $urandom_range(0, 4);
			stall_left = idle_len();
		end
	end

	// Monitor: every result the block hands over is matched with the oldest
	// prediction, field by field.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (predicted_results.size() == 0) begin
				$error("unexpected result: status %0d cluster %0d read_data %h",
					status, cluster, read_data);
				fail_count++;
			end else begin
				want = predicted_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (cluster !== want.cluster) begin
					$error("cluster: expected %0d, got %0d", want.cluster, cluster);
					fail_count++;
				end
				if (read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, read_data);
					fail_count++;
				end
			end
		end
	end

	task automatic queue_cmd(input func_e_t f, input int unsigned idx,
		input logic [31:0] val, input int unsigned cnt);
		fat_cmd_t c;
		c.func = f;
		c.index = 12'(idx);
		c.value = val;
		c.count = 13'(cnt);
		command_q.push_back(c);
	endtask

	// Waits until every queued item is taken and every predicted result has
	// come back. Each item gives exactly one result, so a short settle time
	// after the last one leaves the block idle.
	task automatic wait_idle();
		int unsigned waited;
		waited = 0;
		do
			@(posedge clk);
		while (command_q.size() != 0 || in_valid);
		while (predicted_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (predicted_results.size() != 0) begin
			$error("%0d predicted results never arrived", predicted_results.size());
			fail_count++;
			predicted_results.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the scan base while the block is idle; the shadow copy changes
	// at the edge of the handshake.
	task automatic set_scan_base(input logic [11:0] base);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= base;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		scan_base = base;
	endtask

	initial begin : stimulus
		logic [11:0] bases[5];
		bases = '{12'd4064, 12'd4080, 12'd4090, 12'd4072, 12'd4088};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items with the scan base still at its reset value:
		// extreme indexes and values, an allocation that takes the free
		// entry with bit 31 set at the scan base, and an extend of zero
		// count. Entry 2 is written first so the scan stops right there.
		queue_cmd(FUNC_WRITE, 0, 32'hFFFF_FFFF, 0);
		queue_cmd(FUNC_READ, 0, 32'h0, TBL_ENTRIES);
		queue_cmd(FUNC_WRITE, 4095, 32'h0, 0);
		queue_cmd(FUNC_READ, 4095, 32'hFFFF_FFFF, 0);
		queue_cmd(FUNC_WRITE, 2, 32'h8000_0000, 0);
		queue_cmd(FUNC_ALLOC, 4095, 32'h5A5A_A5A5, 8191 & 4095);
		queue_cmd(FUNC_EXTEND, 5, 32'h0, 0);
		queue_cmd(FUNC_READ, 2, 32'h0, 0);
		wait_idle();

		// Load the top of the table. The block starts with an undefined
		// table, and every later scan range lies in this region, so nothing
		// is read or scanned before it holds a known value.
		set_scan_base(12'(LOAD_BASE));
		for (int unsigned i = LOAD_BASE; i < TBL_ENTRIES; i++)
			queue_cmd(FUNC_WRITE, i, entry_value(), $urandom_range(0, TBL_ENTRIES));
		// An extend from a free tail, which is skipped by the scan.
		queue_cmd(FUNC_WRITE, 4094, 32'h8000_0000, 0);
		queue_cmd(FUNC_WRITE, 4070, 32'h0, 0);
		queue_cmd(FUNC_EXTEND, 4070, 32'h0, 2);
		queue_cmd(FUNC_READ, 4070, 32'h0, 0);
		wait_idle();

		// Scan range of a single entry: the last entry is taken, then the
		// table is full; a free tail in the range is skipped, so the extend
		// finds no room and turns the tail into a chain end.
		set_scan_base(12'd4095);
		queue_cmd(FUNC_ALLOC, 0, 32'h0, 0);
		queue_cmd(FUNC_ALLOC, 0, 32'h0, 0);
		queue_cmd(FUNC_WRITE, 4095, 32'h8000_0000, 0);
		queue_cmd(FUNC_EXTEND, 4095, 32'h0, 1);
		queue_cmd(FUNC_READ, 4095, 32'h0, 0);
		queue_cmd(FUNC_EXTEND, 100, 32'h0, TBL_ENTRIES);
		queue_cmd(FUNC_READ, 100, 32'h0, 0);
		wait_idle();

		// Whole loaded range: an extend by the table size can never succeed
		// and releases every free entry; the next extend links the freed ones.
		set_scan_base(12'(LOAD_BASE));
		queue_cmd(FUNC_WRITE, LOAD_BASE, 32'h0, 0);
		queue_cmd(FUNC_ALLOC, 0, 32'h0, 0);
		queue_cmd(FUNC_READ, LOAD_BASE, 32'h0, 0);
		queue_cmd(FUNC_EXTEND, 4070, 32'h0, TBL_ENTRIES);
		queue_cmd(FUNC_EXTEND, 4070, 32'h0, 3);
		queue_cmd(FUNC_READ, 4070, 32'h0, 0);
		wait_idle();

		// Random phases with short scan ranges inside the loaded region.
		foreach (bases[p]) begin
			set_scan_base(bases[p]);
			for (int unsigned n = 0; n < RANDOM_PHASE; n++)
				command_q.push_back(random_command(bases[p]));
			wait_idle();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// The limit leaves a wide margin for a full run with the longest gaps and stalls.
	initial begin : watchdog
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/fcca_pkg.sv
rtl/fcca_table.sv
rtl/fcca_ctrl.sv
rtl/fat_cluster_chain_allocator_core.sv
test/tb_fat_cluster_chain_allocator_core.sv
